// ===== design/ctu_pkg.sv =====
// Shared types, register map and constants for the calibrated thermostat control unit.
package ctu_pkg;

  localparam int unsigned RawW     = 12;
  localparam int unsigned GainW    = 20;
  localparam int unsigned TempW    = 16;
  localparam int unsigned ToffW    = 8;
  localparam int unsigned HystW    = 15;
  localparam int unsigned CmpW     = 18;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned ProdW    = RawW + GainW + 1;

  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SENS_OFF  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THERM_OFF = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HYST      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HEAT_SP   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COOL_SP   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 3'd6;

  localparam logic [GainW-1:0]        RESET_GAIN    = 20'd409600;
  localparam logic signed [TempW-1:0] RESET_HEAT_SP = 16'sd2100;
  localparam logic signed [TempW-1:0] RESET_COOL_SP = 16'sd2400;
  localparam logic [HystW-1:0]        RESET_HYST    = 15'd15;
  localparam logic [TempW-1:0]        INVALID_TEMP  = 16'h8000;
  localparam logic [2:0]              FAIL_LIMIT    = 3'd7;

  localparam logic [ModeW-1:0] MODE_OFF      = 3'd0;
  localparam logic [ModeW-1:0] MODE_AUTO     = 3'd1;
  localparam logic [ModeW-1:0] MODE_NONE     = 3'd2;
  localparam logic [ModeW-1:0] MODE_COOL     = 3'd3;
  localparam logic [ModeW-1:0] MODE_HEAT     = 3'd4;
  localparam logic [ModeW-1:0] MODE_EMER     = 3'd5;
  localparam logic [ModeW-1:0] MODE_PRECOOL  = 3'd6;
  localparam logic [ModeW-1:0] MODE_OFF_ALT  = 3'd7;

  localparam logic [1:0] RUN_OFF  = 2'd0;
  localparam logic [1:0] RUN_COOL = 2'd1;
  localparam logic [1:0] RUN_HEAT = 2'd2;

  localparam logic [2:0] RELAY_IDLE     = 3'd0;
  localparam logic [2:0] RELAY_SW_OFF   = 3'd4;
  localparam logic [2:0] RELAY_HEAT_ON  = 3'd5;
  localparam logic [2:0] RELAY_COOL_ON  = 3'd6;

  typedef struct packed {
    logic signed [RawW-1:0] raw_reading;
    logic                   read_ok;
  } ctu_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] measured_temp;
    logic signed [TempW-1:0] offset_temp;
    logic                    heating;
    logic                    cooling;
    logic [1:0]              demand_mode;
    logic [2:0]              relay_bits;
    logic                    relay_cmd_valid;
    logic                    relay_on;
    logic [1:0]              error_flags;
  } ctu_out_t;

  // bit0 heat takes part, bit1 cool takes part
  function automatic logic [1:0] mode_bits(input logic [ModeW-1:0] mode);
    logic [1:0] bits;
    bits = 2'b00;
    case (mode)
      MODE_AUTO:               bits = 2'b11;
      MODE_COOL, MODE_PRECOOL: bits = 2'b10;
      MODE_HEAT, MODE_EMER:    bits = 2'b01;
      default:                 bits = 2'b00;
    endcase
    return bits;
  endfunction

endpackage

// ===== design/calibrated_thermostat_control_unit.sv =====
// Top level: register stage, calibration, hysteresis thermostat and failure tracking.
// Registers: an accepted reading passes the product register, then the result register.
// Throughput: one transaction per cycle if not stalled; the scaling multiplier sits alone
// before the first register, the offsets and setpoint compares before the result register.
// Reset: asynchronous active low; registers return to their reset values, thermostat and
// failure state clear, no transaction is pending.
module calibrated_thermostat_control_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ctu_pkg::ctu_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ctu_pkg::ctu_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ctu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ctu_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [ctu_pkg::GainW-1:0]        gain_q;
  logic signed [ctu_pkg::TempW-1:0] sens_off_q;
  logic signed [ctu_pkg::ToffW-1:0] therm_off_q;
  logic [ctu_pkg::HystW-1:0]        hyst_q;
  logic signed [ctu_pkg::TempW-1:0] heat_sp_q;
  logic signed [ctu_pkg::TempW-1:0] cool_sp_q;
  logic [ctu_pkg::ModeW-1:0]        mode_q;

  logic                       s1_valid_q;
  logic                       s1_ok_q;
  logic [ctu_pkg::TempW-1:0]  s1_scaled_q;
  logic                       out_valid_q;
  ctu_pkg::ctu_out_t          out_data_q;

  logic                       heat_q, heat_d;
  logic                       cool_q, cool_d;
  logic [2:0]                 relay_q, relay_d;
  logic [2:0]                 fail_q, fail_d;
  logic [1:0]                 sticky_q, sticky_d;
  logic [ctu_pkg::TempW-1:0]  last_meas_q, last_meas_d;
  logic [ctu_pkg::TempW-1:0]  last_local_q, last_local_d;

  logic                                out_load;
  logic                                s1_adv;
  logic                                in_take;
  logic signed [ctu_pkg::ProdW-1:0]    prod;
  logic [ctu_pkg::TempW-1:0]           meas;
  logic [ctu_pkg::TempW-1:0]           local_t;
  logic signed [ctu_pkg::CmpW-1:0]     temp_x;
  logic signed [ctu_pkg::CmpW-1:0]     heat_hi, heat_lo, cool_hi, cool_lo;
  logic signed [ctu_pkg::CmpW-1:0]     hyst_x;
  logic [1:0]                          bits;
  logic                                cmd_valid;
  logic [1:0]                          demand;
  ctu_pkg::ctu_out_t                   res;

  assign cfg_ready_o = 1'b1;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_load;
  assign in_stall_o  = s1_valid_q && !out_load;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= ctu_pkg::RESET_GAIN;
      sens_off_q  <= '0;
      therm_off_q <= '0;
      hyst_q      <= ctu_pkg::RESET_HYST;
      heat_sp_q   <= ctu_pkg::RESET_HEAT_SP;
      cool_sp_q   <= ctu_pkg::RESET_COOL_SP;
      mode_q      <= ctu_pkg::MODE_OFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ctu_pkg::CFG_GAIN:      gain_q      <= cfg_data_i;
        ctu_pkg::CFG_SENS_OFF:  sens_off_q  <= cfg_data_i[ctu_pkg::TempW-1:0];
        ctu_pkg::CFG_THERM_OFF: therm_off_q <= cfg_data_i[ctu_pkg::ToffW-1:0];
        ctu_pkg::CFG_HYST:      hyst_q      <= cfg_data_i[ctu_pkg::HystW-1:0];
        ctu_pkg::CFG_HEAT_SP:   heat_sp_q   <= cfg_data_i[ctu_pkg::TempW-1:0];
        ctu_pkg::CFG_COOL_SP:   cool_sp_q   <= cfg_data_i[ctu_pkg::TempW-1:0];
        ctu_pkg::CFG_MODE:      mode_q      <= cfg_data_i[ctu_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  // scale: floor(raw * gain / 2^16), only the low 16 bits are kept
  assign prod = ctu_pkg::ProdW'(in_data_i.raw_reading) * $signed({1'b0, gain_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_ok_q     <= in_data_i.read_ok;
      s1_scaled_q <= prod[ctu_pkg::TempW+15:16];
    end
  end

  always_comb begin
    meas    = s1_scaled_q + sens_off_q;
    local_t = meas + {{(ctu_pkg::TempW-ctu_pkg::ToffW){therm_off_q[ctu_pkg::ToffW-1]}},
                      therm_off_q};
    temp_x  = ctu_pkg::CmpW'($signed(local_t));
    hyst_x  = $signed({{(ctu_pkg::CmpW-ctu_pkg::HystW){1'b0}}, hyst_q});
    heat_hi = ctu_pkg::CmpW'(heat_sp_q) + hyst_x;
    heat_lo = ctu_pkg::CmpW'(heat_sp_q) - hyst_x;
    cool_hi = ctu_pkg::CmpW'(cool_sp_q) + hyst_x;
    cool_lo = ctu_pkg::CmpW'(cool_sp_q) - hyst_x;
    bits    = ctu_pkg::mode_bits(mode_q);

    heat_d       = heat_q;
    cool_d       = cool_q;
    relay_d      = relay_q;
    fail_d       = fail_q;
    sticky_d     = sticky_q;
    last_meas_d  = last_meas_q;
    last_local_d = last_local_q;
    cmd_valid    = 1'b0;

    if (s1_ok_q) begin
      last_meas_d  = meas;
      last_local_d = local_t;
      fail_d       = '0;
      if (bits == 2'b00) begin
        heat_d  = 1'b0;
        cool_d  = 1'b0;
        relay_d = ctu_pkg::RELAY_IDLE;
      end else begin
        if (bits[0]) begin
          if (heat_q) begin
            if (temp_x > heat_hi) begin
              heat_d  = 1'b0;
              relay_d = ctu_pkg::RELAY_SW_OFF;
            end
          end else if (temp_x < heat_lo) begin
            heat_d  = 1'b1;
            relay_d = ctu_pkg::RELAY_HEAT_ON;
          end
        end else begin
          heat_d = 1'b0;
        end
        // cool runs second so its relay write wins
        if (bits[1]) begin
          if (cool_q) begin
            if (temp_x < cool_lo) begin
              cool_d  = 1'b0;
              relay_d = ctu_pkg::RELAY_SW_OFF;
            end
          end else if (temp_x > cool_hi) begin
            cool_d  = 1'b1;
            relay_d = ctu_pkg::RELAY_COOL_ON;
          end
        end else begin
          cool_d = 1'b0;
        end
        cmd_valid = 1'b1;
      end
    end else begin
      sticky_d[0] = 1'b1;
      if (fail_q == ctu_pkg::FAIL_LIMIT) begin
        fail_d       = '0;
        sticky_d[1]  = 1'b1;
        last_meas_d  = ctu_pkg::INVALID_TEMP;
        last_local_d = ctu_pkg::INVALID_TEMP;
      end else begin
        fail_d = fail_q + 3'd1;
      end
    end

    if (heat_d) begin
      demand = ctu_pkg::RUN_HEAT;
    end else if (cool_d) begin
      demand = ctu_pkg::RUN_COOL;
    end else begin
      demand = ctu_pkg::RUN_OFF;
    end

    res.measured_temp   = last_meas_d;
    res.offset_temp     = last_local_d;
    res.heating         = heat_d;
    res.cooling         = cool_d;
    res.demand_mode     = demand;
    res.relay_bits      = relay_d;
    res.relay_cmd_valid = cmd_valid;
    res.relay_on        = cmd_valid && (demand != ctu_pkg::RUN_OFF);
    res.error_flags     = sticky_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q       <= 1'b0;
      cool_q       <= 1'b0;
      relay_q      <= ctu_pkg::RELAY_IDLE;
      fail_q       <= '0;
      sticky_q     <= '0;
      last_meas_q  <= '0;
      last_local_q <= '0;
    end else if (s1_adv) begin
      heat_q       <= heat_d;
      cool_q       <= cool_d;
      relay_q      <= relay_d;
      fail_q       <= fail_d;
      sticky_q     <= sticky_d;
      last_meas_q  <= last_meas_d;
      last_local_q <= last_local_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

endmodule

// ===== bench/calibrated_thermostat_control_unit_test.sv =====
// Testbench for the calibrated thermostat control unit: directed and random readings checked per field.
`timescale 1ns / 100ps

module calibrated_thermostat_control_unit_test;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  ctu_pkg::ctu_in_t             in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  ctu_pkg::ctu_out_t            out_data_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [ctu_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ctu_pkg::CfgDataW-1:0] cfg_data_i;

  calibrated_thermostat_control_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Register mirror
  logic [ctu_pkg::GainW-1:0]        gain_q      = ctu_pkg::RESET_GAIN;
  logic signed [ctu_pkg::TempW-1:0] sens_off_q  = '0;
  logic signed [ctu_pkg::ToffW-1:0] therm_off_q = '0;
  logic [ctu_pkg::HystW-1:0]        hyst_q      = ctu_pkg::RESET_HYST;
  logic signed [ctu_pkg::TempW-1:0] heat_sp_q   = ctu_pkg::RESET_HEAT_SP;
  logic signed [ctu_pkg::TempW-1:0] cool_sp_q   = ctu_pkg::RESET_COOL_SP;
  logic [ctu_pkg::ModeW-1:0]        mode_q      = ctu_pkg::MODE_OFF;

  // Thermostat and failure state mirror
  logic                      heat_on_q    = 1'b0;
  logic                      cool_on_q    = 1'b0;
  logic [2:0]                relay_q      = ctu_pkg::RELAY_IDLE;
  logic [2:0]                fail_run_q   = '0;
  logic [1:0]                sticky_q     = '0;
  logic [ctu_pkg::TempW-1:0] last_meas_q  = '0;
  logic [ctu_pkg::TempW-1:0] last_local_q = '0;

  logic [ctu_pkg::ModeW-1:0] mode_list [8] = '{ctu_pkg::MODE_OFF, ctu_pkg::MODE_AUTO,
                                               ctu_pkg::MODE_NONE, ctu_pkg::MODE_COOL,
                                               ctu_pkg::MODE_HEAT, ctu_pkg::MODE_EMER,
                                               ctu_pkg::MODE_PRECOOL, ctu_pkg::MODE_OFF_ALT};

  ctu_pkg::ctu_out_t pending_results[$];
  int       mismatches = 0;
  bit       send_idle  = 1'b0;
  bit       stall_on   = 1'b0;
  int       stall_left = 0;

  function automatic ctu_pkg::ctu_out_t thermostat_step(input ctu_pkg::ctu_in_t reading);
    ctu_pkg::ctu_out_t                res;
    longint                           prod;
    longint                           scaled;
    logic [ctu_pkg::TempW-1:0]        meas;
    logic signed [ctu_pkg::TempW-1:0] temp;
    logic                             heat_part;
    logic                             cool_part;
    logic                             cmd;
    int                               t;
    int                               hy;
    res = '0;
    cmd = 1'b0;
    heat_part = 1'b0;
    cool_part = 1'b0;
    if (reading.read_ok) begin
      prod = longint'(reading.raw_reading) * longint'(gain_q);
      scaled = prod >>> 16;
      meas = 16'(scaled + longint'(sens_off_q));
      temp = meas + {{(ctu_pkg::TempW-ctu_pkg::ToffW){therm_off_q[ctu_pkg::ToffW-1]}},
                     therm_off_q};
      last_meas_q = meas;
      last_local_q = temp;
      fail_run_q = '0;
      case (mode_q)
        ctu_pkg::MODE_AUTO: begin
          heat_part = 1'b1;
          cool_part = 1'b1;
        end
        ctu_pkg::MODE_HEAT, ctu_pkg::MODE_EMER: heat_part = 1'b1;
        ctu_pkg::MODE_COOL, ctu_pkg::MODE_PRECOOL: cool_part = 1'b1;
        default: ;
      endcase
      if (!heat_part && !cool_part) begin
        heat_on_q = 1'b0;
        cool_on_q = 1'b0;
        relay_q = ctu_pkg::RELAY_IDLE;
      end else begin
        t = int'(temp);
        hy = int'(hyst_q);
        if (heat_part) begin
          if (heat_on_q) begin
            if (t > int'(heat_sp_q) + hy) begin
              heat_on_q = 1'b0;
              relay_q = ctu_pkg::RELAY_SW_OFF;
            end
          end else if (t < int'(heat_sp_q) - hy) begin
            heat_on_q = 1'b1;
            relay_q = ctu_pkg::RELAY_HEAT_ON;
          end
        end else begin
          heat_on_q = 1'b0;
        end
        // cool decides last, so its relay write wins
        if (cool_part) begin
          if (cool_on_q) begin
            if (t < int'(cool_sp_q) - hy) begin
              cool_on_q = 1'b0;
              relay_q = ctu_pkg::RELAY_SW_OFF;
            end
          end else if (t > int'(cool_sp_q) + hy) begin
            cool_on_q = 1'b1;
            relay_q = ctu_pkg::RELAY_COOL_ON;
          end
        end else begin
          cool_on_q = 1'b0;
        end
        cmd = 1'b1;
      end
    end else begin
      sticky_q[0] = 1'b1;
      if (fail_run_q >= ctu_pkg::FAIL_LIMIT) begin
        fail_run_q = '0;
        sticky_q[1] = 1'b1;
        last_meas_q = ctu_pkg::INVALID_TEMP;
        last_local_q = ctu_pkg::INVALID_TEMP;
      end else begin
        fail_run_q = fail_run_q + 3'd1;
      end
    end
    res.measured_temp = last_meas_q;
    res.offset_temp = last_local_q;
    res.heating = heat_on_q;
    res.cooling = cool_on_q;
    res.demand_mode = heat_on_q ? ctu_pkg::RUN_HEAT
                                : (cool_on_q ? ctu_pkg::RUN_COOL : ctu_pkg::RUN_OFF);
    res.relay_bits = relay_q;
    res.relay_cmd_valid = cmd;
    res.relay_on = cmd && (res.demand_mode != ctu_pkg::RUN_OFF);
    res.error_flags = sticky_q;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_wide(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (stall_on) stall_left = pick_gap();
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    ctu_pkg::ctu_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("measured_temp", want.measured_temp, out_data_o.measured_temp);
        check_field("offset_temp", want.offset_temp, out_data_o.offset_temp);
        check_field("heating", 16'(want.heating), 16'(out_data_o.heating));
        check_field("cooling", 16'(want.cooling), 16'(out_data_o.cooling));
        check_field("demand_mode", 16'(want.demand_mode), 16'(out_data_o.demand_mode));
        check_field("relay_bits", 16'(want.relay_bits), 16'(out_data_o.relay_bits));
        check_field("relay_cmd_valid", 16'(want.relay_cmd_valid),
                    16'(out_data_o.relay_cmd_valid));
        check_field("relay_on", 16'(want.relay_on), 16'(out_data_o.relay_on));
        check_field("error_flags", 16'(want.error_flags), 16'(out_data_o.error_flags));
      end
    end
  end

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_reading(input logic [ctu_pkg::RawW-1:0] raw, input logic ok);
    ctu_pkg::ctu_in_t reading;
    int               gap;
    reading.raw_reading = raw;
    reading.read_ok = ok;
    gap = send_idle ? pick_gap() : 0;
    repeat (gap) @(negedge clk_i);
    in_data_i = reading;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_results.push_back(thermostat_step(reading));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(input logic [ctu_pkg::CfgIdxW-1:0] idx, input int value);
    wait_idle();
    cfg_index_i = idx;
    cfg_data_i = ctu_pkg::CfgDataW'(value);
    cfg_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      ctu_pkg::CFG_GAIN:      gain_q = cfg_data_i[ctu_pkg::GainW-1:0];
      ctu_pkg::CFG_SENS_OFF:  sens_off_q = cfg_data_i[ctu_pkg::TempW-1:0];
      ctu_pkg::CFG_THERM_OFF: therm_off_q = cfg_data_i[ctu_pkg::ToffW-1:0];
      ctu_pkg::CFG_HYST:      hyst_q = cfg_data_i[ctu_pkg::HystW-1:0];
      ctu_pkg::CFG_HEAT_SP:   heat_sp_q = cfg_data_i[ctu_pkg::TempW-1:0];
      ctu_pkg::CFG_COOL_SP:   cool_sp_q = cfg_data_i[ctu_pkg::TempW-1:0];
      ctu_pkg::CFG_MODE:      mode_q = cfg_data_i[ctu_pkg::ModeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_reset_state();
    send_reading(12'd0, 1'b1);
  endtask

  task automatic test_reading_extremes();
    write_reg(ctu_pkg::CFG_GAIN, (1 << ctu_pkg::GainW) - 1);
    write_reg(ctu_pkg::CFG_SENS_OFF, 32767);
    write_reg(ctu_pkg::CFG_THERM_OFF, 127);
    send_reading(12'h800, 1'b1);
    send_reading(12'h7ff, 1'b1);
    send_reading(12'hfff, 1'b1);
    write_reg(ctu_pkg::CFG_GAIN, 0);
    write_reg(ctu_pkg::CFG_SENS_OFF, -32768);
    write_reg(ctu_pkg::CFG_THERM_OFF, -128);
    send_reading(12'd1234, 1'b1);
    write_reg(ctu_pkg::CFG_GAIN, int'(ctu_pkg::RESET_GAIN));
    write_reg(ctu_pkg::CFG_SENS_OFF, 0);
    write_reg(ctu_pkg::CFG_THERM_OFF, 0);
  endtask

  task automatic test_mode_select();
    write_reg(ctu_pkg::CFG_HYST, 0);
    foreach (mode_list[m]) begin
      write_reg(ctu_pkg::CFG_MODE, int'(mode_list[m]));
      send_reading(12'd100, 1'b1);
    end
  endtask

  task automatic test_auto_both_change();
    write_reg(ctu_pkg::CFG_HYST, int'(ctu_pkg::RESET_HYST));
    write_reg(ctu_pkg::CFG_MODE, int'(ctu_pkg::MODE_AUTO));
    send_reading(12'd400, 1'b1);
    send_reading(12'd100, 1'b1);
  endtask

  task automatic test_failure_run();
    repeat (9) send_reading(12'h5a5, 1'b0);
    send_reading(12'd350, 1'b1);
  endtask

  task automatic test_random_phases();
    int items_left;
    int burst;
    int r;
    int walk;
    int hs;
    bit wild;
    bit paused;
    walk = 300;
    paused = 1'b0;
    for (int ph = 0; ph < 22; ph++) begin
      wild = 1'b0;
      if (ph == 0) begin
        write_reg(ctu_pkg::CFG_HYST, (1 << ctu_pkg::HystW) - 1);
        write_reg(ctu_pkg::CFG_HEAT_SP, -32768);
        write_reg(ctu_pkg::CFG_COOL_SP, 32767);
        write_reg(ctu_pkg::CFG_MODE, int'(ctu_pkg::MODE_AUTO));
      end else if (ph == 1) begin
        write_reg(ctu_pkg::CFG_HYST, 0);
        write_reg(ctu_pkg::CFG_HEAT_SP, 32767);
        write_reg(ctu_pkg::CFG_COOL_SP, -32768);
        write_reg(ctu_pkg::CFG_MODE, int'(ctu_pkg::MODE_AUTO));
      end else if ($urandom_range(0, 9) < 7) begin
        hs = $urandom_range(800, 2800);
        write_reg(ctu_pkg::CFG_GAIN,
                  int'(ctu_pkg::RESET_GAIN) + int'($urandom_range(0, 163840)) - 81920);
        write_reg(ctu_pkg::CFG_SENS_OFF, int'($urandom_range(0, 400)) - 200);
        write_reg(ctu_pkg::CFG_THERM_OFF, pick_wide(-128, 127));
        write_reg(ctu_pkg::CFG_HYST, $urandom_range(0, 60));
        write_reg(ctu_pkg::CFG_HEAT_SP, hs);
        write_reg(ctu_pkg::CFG_COOL_SP, hs + int'($urandom_range(0, 1200)) - 100);
        write_reg(ctu_pkg::CFG_MODE, ($urandom_range(0, 2) == 0)
                                     ? int'(ctu_pkg::MODE_AUTO)
                                     : int'(mode_list[$urandom_range(0, 7)]));
      end else begin
        wild = 1'b1;
        write_reg(ctu_pkg::CFG_GAIN, pick_wide(0, (1 << ctu_pkg::GainW) - 1));
        write_reg(ctu_pkg::CFG_SENS_OFF, pick_wide(-32768, 32767));
        write_reg(ctu_pkg::CFG_THERM_OFF, pick_wide(-128, 127));
        write_reg(ctu_pkg::CFG_HYST, pick_wide(0, (1 << ctu_pkg::HystW) - 1));
        write_reg(ctu_pkg::CFG_HEAT_SP, pick_wide(-32768, 32767));
        write_reg(ctu_pkg::CFG_COOL_SP, pick_wide(-32768, 32767));
        write_reg(ctu_pkg::CFG_MODE, int'(mode_list[$urandom_range(0, 7)]));
      end
      send_idle = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      items_left = 75;
      while (items_left > 0) begin
        // hold the sender until the pipeline has emptied
        if (ph == 11 && items_left <= 40 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 7) begin
          send_reading(12'($urandom), 1'b0);
          items_left--;
        end else if (r < 10) begin
          burst = $urandom_range(6, 10);
          repeat (burst) send_reading(12'($urandom), 1'b0);
          items_left -= burst;
        end else if (wild || r < 15) begin
          send_reading(12'($urandom), 1'b1);
          items_left--;
        end else begin
          walk += int'($urandom_range(0, 20)) - 10;
          if (walk < -100) walk = -100;
          if (walk > 800) walk = 800;
          send_reading(12'(walk), 1'b1);
          items_left--;
        end
      end
    end
    stall_on = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ctu_pkg::CFG_GAIN;
    cfg_data_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_reading_extremes();
    test_mode_select();
    test_auto_both_change();
    test_failure_run();
    test_random_phases();
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
